/* hdl/nidbb_pkg.sv */
// ----------------------------------------------------------------------------
// nidbb_pkg
// shared constants, beat types and controller/datapath interface structs for
// the newest-id bounded buffer
// ----------------------------------------------------------------------------
`default_nettype none

package nidbb_pkg;

    // built depth of the record store
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths of the beats
    localparam int OP_W  = 2;
    localparam int ID_W  = 31;
    localparam int REF_W = 16;
    localparam int ST_W  = 3;
    localparam int ENT_W = 5;
    localparam int CAP_W = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_STORED  = 3'd0;
    localparam logic [ST_W-1:0] ST_EVICTED = 3'd1;
    localparam logic [ST_W-1:0] ST_DROPPED = 3'd2;
    localparam logic [ST_W-1:0] ST_ENTRY   = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [ST_W-1:0] ST_CLEARED = 3'd5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  chunk_id;
        logic [REF_W-1:0] payload_ref;
    } in_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  out_id;
        logic [REF_W-1:0] out_ref;
        logic [ENT_W-1:0] entry_count;
        logic             last;
    } out_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [REF_W-1:0] ref_val;
    } rec_t;

    // controller to datapath
    typedef struct packed {
        logic             load_in;
        logic             scan_start;
        logic             rd_en;
        logic [IDX_W-1:0] addr;
        logic             store;
        logic             resolve;
        logic             emit_entry;
        logic             sort_last;
        logic             emit_empty;
        logic             clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             full;
        logic             empty;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } sts_t;

    // capacity as used: zero acts as one, above the depth acts as the depth
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (int'(v) > DEPTH)
            r = CNT_W'(DEPTH);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/newest_id_bounded_buffer.sv */
// throughput: one operation at a time; the slot scan reads one slot per cycle
//   from the record memory, once per emitted record on a read
// reset: asynchronous, store empty, capacity 16, no result pending
// ----------------------------------------------------------------------------
// newest_id_bounded_buffer
// bounded record store that keeps the highest sequence ids, evicting the
// lowest when full, with sorted read-out and clear
// ----------------------------------------------------------------------------
`default_nettype none

module newest_id_bounded_buffer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  nidbb_pkg::in_t                   in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output nidbb_pkg::out_t                  out_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [nidbb_pkg::CAP_W-1:0] cfg_wr_data
);

    nidbb_pkg::cmd_t cmd;
    nidbb_pkg::sts_t sts;

    nidbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    nidbb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

/* hdl/nidbb_ctrl.sv */
// ----------------------------------------------------------------------------
// nidbb_ctrl
// sequencer: decodes the held operation, walks the slot scans and the sort
// passes, and paces result beats against the output register
// ----------------------------------------------------------------------------
`default_nettype none

module nidbb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  nidbb_pkg::sts_t      sts,
    output nidbb_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_STORE   = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_DRAIN   = 4'd4;
    localparam logic [3:0] S_REPLACE = 4'd5;
    localparam logic [3:0] S_ENTRY   = 4'd6;
    localparam logic [3:0] S_EMPTY   = 4'd7;
    localparam logic [3:0] S_CLEAR   = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic [nidbb_pkg::IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [nidbb_pkg::IDX_W-1:0] pass_idx_reg, pass_idx_next;
    logic                        scan_last, pass_last;

    assign scan_last = (nidbb_pkg::CNT_W'(scan_idx_reg) + nidbb_pkg::CNT_W'(1)) == sts.count;
    assign pass_last = (nidbb_pkg::CNT_W'(pass_idx_reg) + nidbb_pkg::CNT_W'(1)) == sts.count;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.addr      = scan_idx_reg;
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        pass_idx_next = pass_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                scan_idx_next = '0;
                pass_idx_next = '0;
                unique case (sts.op)
                    nidbb_pkg::OP_ADD:
                    begin
                        if (sts.full)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        else
                            state_next = S_STORE;
                    end
                    nidbb_pkg::OP_READ:
                    begin
                        if (sts.empty)
                            state_next = S_EMPTY;
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    nidbb_pkg::OP_CLEAR: state_next = S_CLEAR;
                    default:             state_next = S_IDLE;
                endcase
            end
            S_STORE:
            begin
                if (sts.out_free)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (scan_last)
                    state_next = S_DRAIN;
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end
            S_DRAIN:
            begin
                // last read beat is compared during this cycle
                state_next = (sts.op == nidbb_pkg::OP_READ) ? S_ENTRY : S_REPLACE;
            end
            S_REPLACE:
            begin
                if (sts.out_free)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_ENTRY:
            begin
                cmd.addr      = pass_idx_reg;
                cmd.sort_last = pass_last;
                if (sts.out_free)
                begin
                    cmd.emit_entry = 1'b1;
                    if (pass_last)
                        state_next = S_IDLE;
                    else
                    begin
                        pass_idx_next  = pass_idx_reg + 1'b1;
                        scan_idx_next  = '0;
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (sts.out_free)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            pass_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            pass_idx_reg <= pass_idx_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/nidbb_dp.sv */
// ----------------------------------------------------------------------------
// nidbb_dp
// record store in two banks, fill count, min search and output register
// ----------------------------------------------------------------------------
`default_nettype none

module nidbb_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  nidbb_pkg::in_t                   in_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [nidbb_pkg::CAP_W-1:0] cfg_wr_data,
    input  nidbb_pkg::cmd_t                  cmd,
    output nidbb_pkg::sts_t                  sts,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output nidbb_pkg::out_t                  out_data
);

    localparam int KEY_W = nidbb_pkg::ID_W + nidbb_pkg::IDX_W;

    // slots 0..count-1 always hold the records; banks swap after a sorted read
    nidbb_pkg::rec_t mem0 [nidbb_pkg::DEPTH];
    nidbb_pkg::rec_t mem1 [nidbb_pkg::DEPTH];

    logic [nidbb_pkg::CNT_W-1:0] cap_reg, count_reg, count_next;
    logic                        bank_reg;
    logic [nidbb_pkg::OP_W-1:0]  op_reg;
    logic [nidbb_pkg::ID_W-1:0]  nid_reg;
    logic [nidbb_pkg::REF_W-1:0] nref_reg;

    nidbb_pkg::rec_t             rd0_reg, rd1_reg, rd_rec;
    logic                        rd_valid_reg;
    logic [nidbb_pkg::IDX_W-1:0] rd_slot_reg;

    logic                        found_reg, have_last_reg;
    nidbb_pkg::rec_t             best_reg;
    logic [nidbb_pkg::IDX_W-1:0] best_slot_reg;
    logic [KEY_W-1:0]            last_key_reg;
    logic [KEY_W-1:0]            rd_key, best_key;
    logic                        take, newer;

    logic                        wr_en, wr_bank;
    logic [nidbb_pkg::IDX_W-1:0] wr_addr;
    nidbb_pkg::rec_t             wr_rec;

    logic                        out_valid_reg;
    nidbb_pkg::out_t             out_reg, out_next;
    logic                        emit;

    assign rd_rec   = bank_reg ? rd1_reg : rd0_reg;
    assign rd_key   = {rd_rec.id, rd_slot_reg};
    assign best_key = {best_reg.id, best_slot_reg};
    // next record in (id, slot) order after the one last emitted
    assign take = rd_valid_reg
                  && (!have_last_reg || (rd_key > last_key_reg))
                  && (!found_reg || (rd_key < best_key));
    assign newer = found_reg && (best_reg.id < nid_reg);

    assign sts.op       = op_reg;
    assign sts.full     = (count_reg >= cap_reg);
    assign sts.empty    = (count_reg == '0);
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.count    = count_reg;

    always_comb
    begin
        if (cfg_wr_en || cmd.clear)
            count_next = '0;
        else if (cmd.store)
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_bank = bank_reg;
        wr_addr = count_reg[nidbb_pkg::IDX_W-1:0];
        wr_rec  = '{id: nid_reg, ref_val: nref_reg};
        priority if (cmd.store)
            wr_en = 1'b1;
        else if (cmd.resolve)
        begin
            wr_en   = newer;
            wr_addr = best_slot_reg;
        end
        else if (cmd.emit_entry)
        begin
            wr_en   = 1'b1;
            wr_bank = ~bank_reg;
            wr_addr = cmd.addr;
            wr_rec  = best_reg;
        end
    end

    always_comb
    begin
        emit     = cmd.store || cmd.resolve || cmd.emit_entry || cmd.emit_empty || cmd.clear;
        out_next = '{status: nidbb_pkg::ST_STORED, out_id: '0, out_ref: '0,
                     entry_count: nidbb_pkg::ENT_W'(count_next), last: 1'b1};
        priority if (cmd.resolve)
        begin
            if (newer)
            begin
                out_next.status  = nidbb_pkg::ST_EVICTED;
                out_next.out_id  = best_reg.id;
                out_next.out_ref = best_reg.ref_val;
            end
            else
            begin
                out_next.status  = nidbb_pkg::ST_DROPPED;
                out_next.out_id  = nid_reg;
                out_next.out_ref = nref_reg;
            end
        end
        else if (cmd.emit_entry)
        begin
            out_next.status  = nidbb_pkg::ST_ENTRY;
            out_next.out_id  = best_reg.id;
            out_next.out_ref = best_reg.ref_val;
            out_next.last    = cmd.sort_last;
        end
        else if (cmd.emit_empty)
            out_next.status = nidbb_pkg::ST_EMPTY;
        else if (cmd.clear)
            out_next.status = nidbb_pkg::ST_CLEARED;
    end

    // store banks
    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_bank)
            mem0[wr_addr] <= wr_rec;
        if (cmd.rd_en)
            rd0_reg <= mem0[cmd.addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_bank)
            mem1[wr_addr] <= wr_rec;
        if (cmd.rd_en)
            rd1_reg <= mem1[cmd.addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= in_data.op;
            nid_reg  <= in_data.chunk_id;
            nref_reg <= in_data.payload_ref;
        end
        rd_slot_reg <= cmd.addr;
        if (take)
        begin
            best_reg      <= rd_rec;
            best_slot_reg <= rd_slot_reg;
        end
        if (cmd.emit_entry)
            last_key_reg <= best_key;
        if (emit)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= nidbb_pkg::eff_cap(nidbb_pkg::CAP_RESET);
            count_reg     <= '0;
            bank_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            have_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= nidbb_pkg::eff_cap(cfg_wr_data);
            count_reg    <= count_next;
            rd_valid_reg <= cmd.rd_en;
            if (cmd.emit_entry && cmd.sort_last)
                bank_reg <= ~bank_reg;
            if (cmd.scan_start)
                found_reg <= 1'b0;
            else if (take)
                found_reg <= 1'b1;
            if (cmd.load_in)
                have_last_reg <= 1'b0;
            else if (cmd.emit_entry)
                have_last_reg <= 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* hdl/nidbb_checker.sv */
// ----------------------------------------------------------------------------
// nidbb_checker
// port-level checks on the result beats of the newest-id bounded buffer
// ----------------------------------------------------------------------------
`default_nettype none

module nidbb_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input nidbb_pkg::out_t                  out_data
);

    logic                       beat;
    logic                       mid_read_reg;
    logic [nidbb_pkg::ID_W-1:0] prev_id_reg;

    assign beat = out_valid && !out_stall;

    // remembers the id of every accepted beat, and whether it was an entry beat that was not the last of its read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_read_reg <= 1'b0;
            prev_id_reg  <= '0;
        end
        else if (beat)
        begin
            mid_read_reg <= (out_data.status == nidbb_pkg::ST_ENTRY) && !out_data.last;
            prev_id_reg  <= out_data.out_id;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_read_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        beat && mid_read_reg |->
            out_data.status == nidbb_pkg::ST_ENTRY && out_data.out_id >= prev_id_reg)
        else $error("read entries out of ascending id order");

    a_busy_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == nidbb_pkg::ST_ENTRY && !out_data.last |-> in_stall)
        else $error("input taken while a read is still emitting");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != nidbb_pkg::ST_ENTRY |->
            out_data.last && (out_data.status != nidbb_pkg::ST_CLEARED
                              || out_data.entry_count == '0))
        else $error("single-beat result without last or clear with entries");

endmodule

bind newest_id_bounded_buffer nidbb_checker u_nidbb_checker (.*);

`default_nettype wire

/* test/tb_newest_id_bounded_buffer.sv */
// ----------------------------------------------------------------------------
// tb_newest_id_bounded_buffer
// self-checking bench for the newest-id bounded buffer: directed corner cases
// for capacity, eviction, drop and read ordering, then random add/read/clear
// traffic under three idle/stall mixes, each beat checked against a
// cycle-free model of the record store
// ----------------------------------------------------------------------------
`default_nettype none

module tb_newest_id_bounded_buffer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 300;   // slowest op: read of 16 records
    localparam int WATCHDOG_LIMIT = 4000;
    // not decoded by the block
    localparam logic [nidbb_pkg::OP_W-1:0] OP_NONE = 2'd3;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    nidbb_pkg::in_t                 in_data     = '0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    nidbb_pkg::out_t                out_data;
    logic                           cfg_wr_en   = 1'b0;
    logic [nidbb_pkg::CAP_W-1:0]    cfg_wr_data = '0;

    // model of the record store
    logic [nidbb_pkg::CAP_W-1:0]    cap_reg = nidbb_pkg::CAP_RESET;
    bit                             rec_valid [nidbb_pkg::DEPTH];
    bit   [nidbb_pkg::ID_W-1:0]     rec_id    [nidbb_pkg::DEPTH];
    bit   [nidbb_pkg::REF_W-1:0]    rec_ref   [nidbb_pkg::DEPTH];
    int                             rec_count;
    nidbb_pkg::out_t                results_due [$];

    int                             tx_idle_pct  = 24;
    int                             rx_stall_pct = 55;
    bit   [nidbb_pkg::ID_W-1:0]     id_cursor    = '0;
    int                             n_errors     = 0;
    int                             n_ops        = 0;
    int                             n_checked    = 0;
    int                             n_evicted    = 0;
    int                             n_dropped    = 0;
    int                             n_reads      = 0;
    int                             n_cfg        = 0;
    int                             idle_cycles  = 0;

    newest_id_bounded_buffer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        begin
            n_errors++;
            $display("%0t ns mismatch %s: expected 0x%0h got 0x%0h", $realtime, what,
                     exp_v, got_v);
        end
    endtask

    function automatic int cap_in_use();
        begin
            if (cap_reg == '0)
                return 1;
            if (int'(cap_reg) > nidbb_pkg::DEPTH)
                return nidbb_pkg::DEPTH;
            return int'(cap_reg);
        end
    endfunction

    function automatic void empty_store();
        begin
            for (int i = 0; i < nidbb_pkg::DEPTH; i++)
                rec_valid[i] = 1'b0;
            rec_count = 0;
        end
    endfunction

    function automatic void result_due(input logic [nidbb_pkg::ST_W-1:0] st,
                                       input logic [nidbb_pkg::ID_W-1:0] id,
                                       input logic [nidbb_pkg::REF_W-1:0] rf,
                                       input logic lst);
        nidbb_pkg::out_t e;
        begin
            e.status      = st;
            e.out_id      = id;
            e.out_ref     = rf;
            e.entry_count = nidbb_pkg::ENT_W'(rec_count);
            e.last        = lst;
            results_due.push_back(e);
        end
    endfunction

    // advance the store by one accepted beat and queue the beats it must produce
    function automatic void buffer_apply(input nidbb_pkg::in_t b);
        int                         lim;
        int                         pos;
        int                         n;
        int                         j;
        bit                         found;
        bit [nidbb_pkg::ID_W-1:0]   tid  [nidbb_pkg::DEPTH];
        bit [nidbb_pkg::REF_W-1:0]  tref [nidbb_pkg::DEPTH];
        begin
            lim = cap_in_use();
            case (b.op)
                nidbb_pkg::OP_ADD:
                begin
                    if (rec_count < lim)
                    begin
                        found = 1'b0;
                        for (int i = 0; i < lim; i++)
                        begin
                            if (!found && !rec_valid[i])
                            begin
                                found        = 1'b1;
                                rec_valid[i] = 1'b1;
                                rec_id[i]    = b.chunk_id;
                                rec_ref[i]   = b.payload_ref;
                            end
                        end
                        rec_count++;
                        result_due(nidbb_pkg::ST_STORED, '0, '0, 1'b1);
                    end
                    else
                    begin
                        found = 1'b0;
                        pos   = 0;
                        for (int i = 0; i < lim; i++)
                        begin
                            if (rec_valid[i] && (!found || rec_id[i] < rec_id[pos]))
                            begin
                                found = 1'b1;
                                pos   = i;
                            end
                        end
                        if (found && rec_id[pos] < b.chunk_id)
                        begin
                            result_due(nidbb_pkg::ST_EVICTED, rec_id[pos], rec_ref[pos], 1'b1);
                            rec_id[pos]  = b.chunk_id;
                            rec_ref[pos] = b.payload_ref;
                            n_evicted++;
                        end
                        else
                        begin
                            result_due(nidbb_pkg::ST_DROPPED, b.chunk_id, b.payload_ref, 1'b1);
                            n_dropped++;
                        end
                    end
                end
                nidbb_pkg::OP_READ:
                begin
                    n_reads++;
                    if (rec_count == 0)
                        result_due(nidbb_pkg::ST_EMPTY, '0, '0, 1'b1);
                    else
                    begin
                        // stable insertion sort: equal ids keep slot order
                        n = 0;
                        for (int i = 0; i < lim; i++)
                        begin
                            if (rec_valid[i])
                            begin
                                j = n;
                                while (j > 0 && rec_id[i] < tid[j-1])
                                begin
                                    tid[j]  = tid[j-1];
                                    tref[j] = tref[j-1];
                                    j--;
                                end
                                tid[j]  = rec_id[i];
                                tref[j] = rec_ref[i];
                                n++;
                            end
                        end
                        // the read compacts the store into emitted order
                        for (int i = 0; i < nidbb_pkg::DEPTH; i++)
                        begin
                            rec_valid[i] = (i < n);
                            if (i < n)
                            begin
                                rec_id[i]  = tid[i];
                                rec_ref[i] = tref[i];
                            end
                        end
                        rec_count = n;
                        for (int i = 0; i < n; i++)
                            result_due(nidbb_pkg::ST_ENTRY, tid[i], tref[i], i == n - 1);
                    end
                end
                nidbb_pkg::OP_CLEAR:
                begin
                    empty_store();
                    result_due(nidbb_pkg::ST_CLEARED, '0, '0, 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    // result side: every accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        nidbb_pkg::out_t exp_b;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
                report_mismatch("unexpected result beat, status", '0, out_data.status);
            else
            begin
                exp_b = results_due.pop_front();
                n_checked++;
                if (out_data.status !== exp_b.status)
                    report_mismatch("status", exp_b.status, out_data.status);
                if (out_data.out_id !== exp_b.out_id)
                    report_mismatch("out_id", exp_b.out_id, out_data.out_id);
                if (out_data.out_ref !== exp_b.out_ref)
                    report_mismatch("out_ref", exp_b.out_ref, out_data.out_ref);
                if (out_data.entry_count !== exp_b.entry_count)
                    report_mismatch("entry_count", exp_b.entry_count, out_data.entry_count);
                if (out_data.last !== exp_b.last)
                    report_mismatch("last", exp_b.last, out_data.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         idle_cycles, results_due.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_beat(input nidbb_pkg::in_t b);
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= b;
            do
                @(posedge clk);
            while (in_stall);
            buffer_apply(b);
            if (b.op != OP_NONE)
                n_ops++;
        end
    endtask

    task automatic send_op(input logic [nidbb_pkg::OP_W-1:0] op,
                           input logic [nidbb_pkg::ID_W-1:0] id,
                           input logic [nidbb_pkg::REF_W-1:0] rf);
        nidbb_pkg::in_t b;
        begin
            b.op          = op;
            b.chunk_id    = id;
            b.payload_ref = rf;
            send_beat(b);
        end
    endtask

    // holds the input side off until every expected beat has come back
    task automatic wait_results_done();
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (results_due.size() != 0);
        end
    endtask

    task automatic write_capacity(input logic [nidbb_pkg::CAP_W-1:0] v);
        begin
            wait_results_done();
            // an ignored op may still be in flight
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= v;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            cap_reg = v;
            empty_store();
            n_cfg++;
        end
    endtask

    function automatic nidbb_pkg::in_t random_item();
        nidbb_pkg::in_t b;
        int             r;
        begin
            r = $urandom_range(99);
            if (r < 70)
                b.op = nidbb_pkg::OP_ADD;
            else if (r < 92)
                b.op = nidbb_pkg::OP_READ;
            else if (r < 96)
                b.op = nidbb_pkg::OP_CLEAR;
            else
                b.op = OP_NONE;
            r = $urandom_range(3);
            if (r < 2)
            begin
                // rising ids push out the oldest records
                id_cursor  = id_cursor + nidbb_pkg::ID_W'($urandom_range(3));
                b.chunk_id = id_cursor;
            end
            else if (r == 2)
                b.chunk_id = nidbb_pkg::ID_W'($urandom_range(15));
            else
                b.chunk_id = nidbb_pkg::ID_W'($urandom);
            b.payload_ref = nidbb_pkg::REF_W'($urandom);
            return b;
        end
    endfunction

    function automatic logic [nidbb_pkg::CAP_W-1:0] pick_capacity();
        begin
            case ($urandom_range(9))
                0:       return '0;
                1:       return ($urandom_range(1) != 0) ? nidbb_pkg::CAP_W'(31)
                                                         : nidbb_pkg::CAP_W'(nidbb_pkg::DEPTH);
                2, 3:    return nidbb_pkg::CAP_W'($urandom_range(31));
                default: return nidbb_pkg::CAP_W'($urandom_range(1, 5));
            endcase
        end
    endfunction

    task automatic test_reset_defaults();
        begin
            send_op(nidbb_pkg::OP_READ, '0, '0);
            send_op(nidbb_pkg::OP_ADD, '0, '0);
            send_op(nidbb_pkg::OP_ADD, {nidbb_pkg::ID_W{1'b1}}, {nidbb_pkg::REF_W{1'b1}});
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(5), nidbb_pkg::REF_W'(1));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(5), nidbb_pkg::REF_W'(2));
            send_op(nidbb_pkg::OP_READ, '0, '0);
            send_op(OP_NONE, {nidbb_pkg::ID_W{1'b1}}, {nidbb_pkg::REF_W{1'b1}});
            send_op(nidbb_pkg::OP_CLEAR, '0, '0);
            send_op(nidbb_pkg::OP_READ, '0, '0);
        end
    endtask

    task automatic test_capacity_limits();
        begin
            // zero behaves as one slot
            write_capacity('0);
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(10), nidbb_pkg::REF_W'(16'h0001));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(10), nidbb_pkg::REF_W'(16'h0002));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(11), nidbb_pkg::REF_W'(16'h0003));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(3), nidbb_pkg::REF_W'(16'h0004));
            send_op(nidbb_pkg::OP_READ, '0, '0);
            // tie on the lowest id: lower slot goes first, equal new id is dropped
            write_capacity(nidbb_pkg::CAP_W'(3));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(7), nidbb_pkg::REF_W'(16'h00a0));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(4), nidbb_pkg::REF_W'(16'h00b0));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(4), nidbb_pkg::REF_W'(16'h00c0));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(9), nidbb_pkg::REF_W'(16'h00d0));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(4), nidbb_pkg::REF_W'(16'h00e0));
            send_op(nidbb_pkg::OP_READ, '0, '0);
            // above the depth behaves as the depth
            write_capacity(nidbb_pkg::CAP_W'(31));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(2), nidbb_pkg::REF_W'(16'h5555));
            send_op(nidbb_pkg::OP_ADD, nidbb_pkg::ID_W'(1), nidbb_pkg::REF_W'(16'haaaa));
            send_op(nidbb_pkg::OP_READ, '0, '0);
        end
    endtask

    task automatic test_random_traffic(input int ops_wanted, input int tx_pct,
                                       input int rx_pct);
        nidbb_pkg::in_t b;
        int             done;
        int             since_cfg;
        begin
            tx_idle_pct  = tx_pct;
            rx_stall_pct = rx_pct;
            done         = 0;
            since_cfg    = 0;
            write_capacity(pick_capacity());
            while (done < ops_wanted)
            begin
                if (since_cfg >= 30)
                begin
                    write_capacity(pick_capacity());
                    since_cfg = 0;
                end
                b = random_item();
                send_beat(b);
                if (b.op != OP_NONE)
                begin
                    done++;
                    since_cfg++;
                end
                if ($urandom_range(99) < 3)
                    wait_results_done();
            end
        end
    endtask

    initial
    begin
        empty_store();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_capacity_limits();
        test_random_traffic(85, 24, 55);
        test_random_traffic(85, 55, 24);
        test_random_traffic(85, 0, 0);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("results never produced", results_due.size(), '0);

        $display("covered %0d operations: %0d reads, %0d evictions, %0d drops, %0d capacity writes",
                 n_ops, n_reads, n_evicted, n_dropped, n_cfg);
        $display("checked %0d result beats, %0d errors", n_checked, n_errors);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/nidbb_pkg.sv
hdl/nidbb_ctrl.sv
hdl/nidbb_dp.sv
hdl/newest_id_bounded_buffer.sv
hdl/nidbb_checker.sv
test/tb_newest_id_bounded_buffer.sv
